// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Line sensor PID steering package
// Shared payload types, register indexes, microcode format and the
// microcode program of the steering sequencer.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int IntegralBits = 24;
   localparam int StepBits     = 4;
   localparam int DivBits      = 19;
   localparam int DivCntBits   = 5;
   localparam int MulABits     = 34;
   localparam int MulBBits     = 25;
   localparam int ProdBits     = MulABits + MulBBits;
   localparam int AccBits      = 42;

   localparam logic [2:0] RegPropGain      = 3'd0;
   localparam logic [2:0] RegIntegGain     = 3'd1;
   localparam logic [2:0] RegDerivGain     = 3'd2;
   localparam logic [2:0] RegBaseSpeed     = 3'd3;
   localparam logic [2:0] RegDarkThreshold = 3'd4;

   localparam logic signed [15:0] PropGainReset  = 16'sd256;
   localparam logic [7:0]         ThresholdReset = 8'd60;
   localparam logic [3:0]         LostPenalty    = 4'd10;

   localparam logic [3:0] OpErr     = 4'd0;
   localparam logic [3:0] OpMul     = 4'd1;
   localparam logic [3:0] OpAccLoad = 4'd2;
   localparam logic [3:0] OpAccAdd  = 4'd3;
   localparam logic [3:0] OpDivInit = 4'd4;
   localparam logic [3:0] OpDivStep = 4'd5;
   localparam logic [3:0] OpDivEnd  = 4'd6;
   localparam logic [3:0] OpSat     = 4'd7;
   localparam logic [3:0] OpFinish  = 4'd8;

   localparam logic [1:0] SelAIgain = 2'd0;
   localparam logic [1:0] SelAProd  = 2'd1;
   localparam logic [1:0] SelAPgain = 2'd2;
   localparam logic [1:0] SelADgain = 2'd3;

   localparam logic [1:0] SelBDt    = 2'd0;
   localparam logic [1:0] SelBInteg = 2'd1;
   localparam logic [1:0] SelBErr   = 2'd2;
   localparam logic [1:0] SelBDerr  = 2'd3;

   localparam logic [StepBits-1:0] StepDivLoop = 4'd8;

   typedef struct packed {
      logic [7:0]  level_far_left;
      logic [7:0]  level_left;
      logic [7:0]  level_mid;
      logic [7:0]  level_right;
      logic [7:0]  level_far_right;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [3:0]  line_error;
      logic               line_lost;
      logic signed [31:0] correction;
      logic signed [31:0] left_speed;
      logic signed [31:0] right_speed;
      logic [31:0]        tracking_cost;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic signed [15:0] deriv_gain;
      logic signed [15:0] base_speed;
      logic [7:0]         dark_threshold;
   } cfg_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [1:0]          a_sel;
      logic [1:0]          b_sel;
      logic                jmp_en;
      logic [StepBits-1:0] jmp_target;
      logic                done;
   } ctrl_word_type;

   typedef struct packed {
      logic          en;
      ctrl_word_type word;
   } seq_ctrl_type;

   function automatic ctrl_word_type microcode(input logic [StepBits-1:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         4'd0: w.op = OpErr;
         4'd1: begin
            w.op = OpMul;
            w.a_sel = SelAIgain;
            w.b_sel = SelBDt;
         end
         4'd2: begin
            w.op = OpMul;
            w.a_sel = SelAProd;
            w.b_sel = SelBInteg;
         end
         4'd3: w.op = OpAccLoad;
         4'd4: begin
            w.op = OpMul;
            w.a_sel = SelAPgain;
            w.b_sel = SelBErr;
         end
         4'd5: w.op = OpAccAdd;
         4'd6: begin
            w.op = OpMul;
            w.a_sel = SelADgain;
            w.b_sel = SelBDerr;
         end
         4'd7: w.op = OpDivInit;
         4'd8: begin
            w.op = OpDivStep;
            w.jmp_en = 1'b1;
            w.jmp_target = StepDivLoop;
         end
         4'd9:  w.op = OpDivEnd;
         4'd10: w.op = OpSat;
         4'd11: begin
            w.op = OpFinish;
            w.done = 1'b1;
         end
         default: begin
            w.op = OpFinish;
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/lsp_sequencer.sv =====
// ----------------------------------------------------------------------------
// Line sensor PID steering sequencer
// Step counter over the microcode program, with a conditional jump for the
// divider loop and a hold on the last step while the result register is full and its output stalls.
// ----------------------------------------------------------------------------
module lsp_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   input  logic                 div_more,
   output logic                 busy,
   output lsp_pkg::seq_ctrl_type ctrl
);
   import lsp_pkg::*;

   logic                run_ff, run_in;
   logic [StepBits-1:0] step_ff, step_in;
   ctrl_word_type       word;
   logic                hold;

   always_comb begin
      word = microcode(step_ff);
      hold = word.done && !out_free;
      ctrl.en = run_ff && !hold;
      ctrl.word = word;
      busy = run_ff;
   end

   always_comb begin
      run_in = run_ff;
      step_in = step_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
         end
         step_in = '0;
      end else if (!hold) begin
         if (word.jmp_en && div_more) begin
            step_in = word.jmp_target;
         end else if (word.done) begin
            run_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff <= run_in;
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/lsp_datapath.sv =====
// ----------------------------------------------------------------------------
// Line sensor PID steering datapath
// Pattern decode, integral and cost update, shared multiplier, accumulator,
// bit-serial divider and output saturation, driven by the control word.
// ----------------------------------------------------------------------------
module lsp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lsp_pkg::req_type      req_data,
   input  lsp_pkg::cfg_type      cfg,
   input  lsp_pkg::seq_ctrl_type ctrl,
   output logic                  div_more,
   output lsp_pkg::rsp_type      result
);
   import lsp_pkg::*;

   localparam logic signed [ProdBits-1:0] ProdTermMax = 59'sd1099511627776;
   localparam logic signed [AccBits-1:0]  TermMax     = 42'sd1099511627776;
   localparam logic signed [AccBits-1:0]  AccI32Max   = 42'sd2147483647;
   localparam logic signed [AccBits-1:0]  AccI32Min   = -42'sd2147483648;
   localparam logic signed [IntegralBits-1:0] IntegMax = {1'b0, {(IntegralBits-1){1'b1}}};
   localparam logic signed [IntegralBits-1:0] IntegMin = {1'b1, {(IntegralBits-1){1'b0}}};

   req_type                   in_ff;
   logic signed [3:0]         e_ff, e_in;
   logic signed [3:0]         prev_ff, prev_in;
   logic                      lost_ff, lost_in;
   logic signed [IntegralBits-1:0] integ_ff, integ_in;
   logic [31:0]               cost_ff, cost_in;
   logic [15:0]               dt_ff, dt_in;
   logic signed [ProdBits-1:0] prod_ff, prod_in;
   logic signed [AccBits-1:0] acc_ff, acc_in;
   logic signed [31:0]        corr_ff, corr_in;
   logic [15:0]               rem_ff, rem_in;
   logic [DivBits-1:0]        quo_ff, quo_in;
   logic [DivCntBits-1:0]     cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;

   logic [4:0]                pat;
   logic                      match;
   logic signed [3:0]         err_new, e_now;
   logic signed [IntegralBits:0] ibase, isum;
   logic [3:0]                cost_add;
   logic [32:0]               csum;
   logic signed [4:0]         derr;
   logic signed [MulABits-1:0] mul_a;
   logic signed [MulBBits-1:0] mul_b;
   logic signed [AccBits-1:0] term;
   logic [ProdBits-1:0]       div_mag;
   logic [16:0]               div_t;
   logic signed [DivBits:0]   quot;
   logic signed [32:0]        left_sum, right_sum;

   always_comb begin
      pat = {in_ff.level_far_left > cfg.dark_threshold,
             in_ff.level_left > cfg.dark_threshold,
             in_ff.level_mid > cfg.dark_threshold,
             in_ff.level_right > cfg.dark_threshold,
             in_ff.level_far_right > cfg.dark_threshold};
      match = 1'b1;
      case (pat)
         5'b00001: err_new = 4'sd4;
         5'b00011: err_new = 4'sd3;
         5'b00010: err_new = 4'sd2;
         5'b00110: err_new = 4'sd1;
         5'b00100: err_new = 4'sd0;
         5'b01100: err_new = -4'sd1;
         5'b01000: err_new = -4'sd2;
         5'b11000: err_new = -4'sd3;
         5'b10000: err_new = -4'sd4;
         default: begin
            err_new = 4'sd0;
            match = 1'b0;
         end
      endcase
      e_now = match ? err_new : e_ff;

      ibase = (e_now == 4'sd0) ? '0 : {integ_ff[IntegralBits-1], integ_ff};
      isum = ibase + {{(IntegralBits-3){e_now[3]}}, e_now};

      cost_add = !match ? LostPenalty : (e_now[3] ? 4'(-e_now) : 4'(e_now));
      csum = {1'b0, cost_ff} + 33'(cost_add);

      derr = {e_ff[3], e_ff} - {prev_ff[3], prev_ff};

      case (ctrl.word.a_sel)
         SelAIgain: mul_a = {{(MulABits-16){cfg.integ_gain[15]}}, cfg.integ_gain};
         SelAProd:  mul_a = prod_ff[MulABits-1:0];
         SelAPgain: mul_a = {{(MulABits-16){cfg.prop_gain[15]}}, cfg.prop_gain};
         default:   mul_a = {{(MulABits-16){cfg.deriv_gain[15]}}, cfg.deriv_gain};
      endcase
      case (ctrl.word.b_sel)
         SelBDt:    mul_b = {{(MulBBits-16){1'b0}}, dt_ff};
         SelBInteg: mul_b = {{(MulBBits-IntegralBits){integ_ff[IntegralBits-1]}}, integ_ff};
         SelBErr:   mul_b = {{(MulBBits-4){e_ff[3]}}, e_ff};
         default:   mul_b = {{(MulBBits-5){derr[4]}}, derr};
      endcase

      if (prod_ff > ProdTermMax) begin
         term = TermMax;
      end else if (prod_ff < -ProdTermMax) begin
         term = -TermMax;
      end else begin
         term = prod_ff[AccBits-1:0];
      end

      div_mag = prod_ff[ProdBits-1] ? ProdBits'(-prod_ff) : ProdBits'(prod_ff);
      div_t = {rem_ff, quo_ff[DivBits-1]};
      quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      div_more = (cnt_ff != DivCntBits'(1));

      left_sum = {cfg.base_speed[15], {16{cfg.base_speed[15]}}, cfg.base_speed}
                 + {corr_ff[31], corr_ff};
      right_sum = {cfg.base_speed[15], {16{cfg.base_speed[15]}}, cfg.base_speed}
                  - {corr_ff[31], corr_ff};
   end

   always_comb begin
      e_in = e_ff;
      prev_in = prev_ff;
      lost_in = lost_ff;
      integ_in = integ_ff;
      cost_in = cost_ff;
      dt_in = dt_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      corr_in = corr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (ctrl.en) begin
         case (ctrl.word.op)
            OpErr: begin
               e_in = e_now;
               lost_in = !match;
               if (isum[IntegralBits] != isum[IntegralBits-1]) begin
                  integ_in = isum[IntegralBits] ? IntegMin : IntegMax;
               end else begin
                  integ_in = isum[IntegralBits-1:0];
               end
               cost_in = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
               dt_in = (in_ff.elapsed_ms == 16'd0) ? 16'd1 : in_ff.elapsed_ms;
            end
            OpMul:     prod_in = mul_a * mul_b;
            OpAccLoad: acc_in = term;
            OpAccAdd:  acc_in = acc_ff + $signed(prod_ff[AccBits-1:0]);
            OpDivInit: begin
               neg_in = prod_ff[ProdBits-1];
               quo_in = div_mag[DivBits-1:0];
               rem_in = '0;
               cnt_in = DivCntBits'(DivBits);
            end
            OpDivStep: begin
               if (div_t >= {1'b0, dt_ff}) begin
                  rem_in = 16'(div_t - {1'b0, dt_ff});
                  quo_in = {quo_ff[DivBits-2:0], 1'b1};
               end else begin
                  rem_in = div_t[15:0];
                  quo_in = {quo_ff[DivBits-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
            end
            OpDivEnd: begin
               acc_in = acc_ff + {{(AccBits-DivBits-1){quot[DivBits]}}, quot};
               prev_in = e_ff;
            end
            OpSat: begin
               if (acc_ff > AccI32Max) begin
                  corr_in = 32'sh7FFF_FFFF;
               end else if (acc_ff < AccI32Min) begin
                  corr_in = -32'sh8000_0000;
               end else begin
                  corr_in = acc_ff[31:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.line_error = e_ff;
      result.line_lost = lost_ff;
      result.correction = corr_ff;
      if (left_sum[32] != left_sum[31]) begin
         result.left_speed = left_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         result.left_speed = left_sum[31:0];
      end
      if (right_sum[32] != right_sum[31]) begin
         result.right_speed = right_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         result.right_speed = right_sum[31:0];
      end
      result.tracking_cost = cost_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
         prev_ff <= '0;
         integ_ff <= '0;
         cost_ff <= '0;
         lost_ff <= 1'b0;
      end else begin
         e_ff <= e_in;
         prev_ff <= prev_in;
         integ_ff <= integ_in;
         cost_ff <= cost_in;
         lost_ff <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_ff <= req_data;
      end
      dt_ff <= dt_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      corr_ff <= corr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== rtl/line_sensor_pid_steer_unit.sv =====
// A new item is accepted only after the previous one has run the microprogram's twelve steps,
// of which the bit-serial divider step runs nineteen times.
// The result register lets the next item enter while a result waits.
// Reset is synchronous and active high; it clears the error, integral and cost
// state and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// Line sensor PID steering unit
// Top level: configuration registers, input handshake, microcoded sequencer,
// datapath and the result register.
// ----------------------------------------------------------------------------
module line_sensor_pid_steer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lsp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import lsp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   rsp_type      result;
   seq_ctrl_type ctrl;
   logic         busy;
   logic         load;
   logic         out_free;
   logic         capture;
   logic         div_more;

   assign load = req_valid && !busy;
   assign req_stall = busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign capture = ctrl.en && ctrl.word.done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   lsp_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (load),
      .out_free (out_free),
      .div_more (div_more),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   lsp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .ctrl     (ctrl),
      .div_more (div_more),
      .result   (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            RegPropGain:      cfg_in.prop_gain = csr_wdata;
            RegIntegGain:     cfg_in.integ_gain = csr_wdata;
            RegDerivGain:     cfg_in.deriv_gain = csr_wdata;
            RegBaseSpeed:     cfg_in.base_speed = csr_wdata;
            RegDarkThreshold: cfg_in.dark_threshold = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain <= PropGainReset;
         cfg_ff.integ_gain <= '0;
         cfg_ff.deriv_gain <= '0;
         cfg_ff.base_speed <= '0;
         cfg_ff.dark_threshold <= ThresholdReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// ===== tb/steer_checker.sv =====
// ----------------------------------------------------------------------------
// Steering checker
// Watches the register port and both channels of the line sensor steering
// unit, predicts each steering result from the accepted sensor sample, and
// compares every result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module steer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lsp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lsp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lsp_pkg::*;

   localparam longint IntegMax  = (longint'(1) << (IntegralBits - 1)) - 1;
   localparam longint IntegMin  = -(longint'(1) << (IntegralBits - 1));
   localparam longint TermLimit = longint'(1) << 40;
   localparam longint WordMax   = 64'sh0000_0000_7FFF_FFFF;
   localparam longint WordMin   = -64'sh0000_0000_8000_0000;
   localparam longint CostMax   = 64'sh0000_0000_FFFF_FFFF;

   logic signed [15:0] prop_gain;
   logic signed [15:0] integ_gain;
   logic signed [15:0] deriv_gain;
   logic signed [15:0] base_speed;
   logic [7:0]         dark_threshold;

   logic signed [3:0]  held_error;
   logic signed [3:0]  prev_error;
   longint             integral_sum;
   logic [31:0]        cost_sum;

   rsp_type            expected_steer[$];
   rsp_type            want;
   int                 errors = 0;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_type predict_tick(input req_type sample);
      logic [4:0] seen;
      logic       lost;
      longint     e;
      longint     dt;
      longint     i_term;
      longint     d_term;
      longint     corr;
      longint     total_cost;
      rsp_type    r;
      seen = {sample.level_far_left > dark_threshold, sample.level_left > dark_threshold,
              sample.level_mid > dark_threshold, sample.level_right > dark_threshold,
              sample.level_far_right > dark_threshold};
      dt = sample.elapsed_ms;
      if (dt == 0) dt = 1;
      lost = 1'b0;
      case (seen)
         5'b00001: held_error = 4'sd4;
         5'b00011: held_error = 4'sd3;
         5'b00010: held_error = 4'sd2;
         5'b00110: held_error = 4'sd1;
         5'b00100: held_error = 4'sd0;
         5'b01100: held_error = -4'sd1;
         5'b01000: held_error = -4'sd2;
         5'b11000: held_error = -4'sd3;
         5'b10000: held_error = -4'sd4;
         default:  lost = 1'b1;
      endcase
      e = held_error;
      if (e == 0) integral_sum = 0;
      integral_sum = clip(integral_sum + e, IntegMin, IntegMax);
      i_term = clip(longint'(integ_gain) * dt * integral_sum, -TermLimit, TermLimit);
      d_term = (longint'(deriv_gain) * (e - longint'(prev_error))) / dt;
      prev_error = held_error;
      corr = clip(longint'(prop_gain) * e + i_term + d_term, WordMin, WordMax);
      r.line_error    = held_error;
      r.line_lost     = lost;
      r.correction    = corr[31:0];
      r.left_speed    = 32'(clip(longint'(base_speed) + corr, WordMin, WordMax));
      r.right_speed   = 32'(clip(longint'(base_speed) - corr, WordMin, WordMax));
      total_cost      = longint'(cost_sum) + (lost ? longint'(LostPenalty) : (e < 0 ? -e : e));
      cost_sum        = (total_cost > CostMax) ? 32'hFFFF_FFFF : total_cost[31:0];
      r.tracking_cost = cost_sum;
      return r;
   endfunction

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         prop_gain      = PropGainReset;
         integ_gain     = '0;
         deriv_gain     = '0;
         base_speed     = '0;
         dark_threshold = ThresholdReset;
         held_error     = '0;
         prev_error     = '0;
         integral_sum   = 0;
         cost_sum       = '0;
         expected_steer.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               RegPropGain:      prop_gain      = csr_wdata;
               RegIntegGain:     integ_gain     = csr_wdata;
               RegDerivGain:     deriv_gain     = csr_wdata;
               RegBaseSpeed:     base_speed     = csr_wdata;
               RegDarkThreshold: dark_threshold = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_steer.size() == 0) begin
               $error("result transfer with no sensor sample outstanding");
               errors++;
            end else begin
               want = expected_steer.pop_front();
               check_field("line_error", want.line_error, rsp_data.line_error);
               check_field("line_lost", want.line_lost, rsp_data.line_lost);
               check_field("correction", want.correction, rsp_data.correction);
               check_field("left_speed", want.left_speed, rsp_data.left_speed);
               check_field("right_speed", want.right_speed, rsp_data.right_speed);
               check_field("tracking_cost", want.tracking_cost, rsp_data.tracking_cost);
            end
         end
         if (req_valid && !req_stall) expected_steer.push_back(predict_tick(req_data));
      end
      fail_count <= errors;
      pending    <= expected_steer.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Line sensor steering unit testbench
// Drives directed and random sensor samples through the steering unit under
// several gain and threshold settings, with random idle bursts on both
// channels, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lsp_pkg::*;

   localparam logic [2:0] RegSpare      = 3'd7;
   localparam int         WatchdogLimit = 2000;
   localparam int         SettleCycles  = 40;
   localparam int         RandomPhases  = 7;
   localparam int         PhaseItems    = 90;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   req_type     req_data     = '0;
   logic        rsp_stall    = 1'b0;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index    = '0;
   logic [15:0] csr_wdata    = '0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int          fail_count;
   int          pending;

   bit          idle_on       = 1'b0;
   int          stall_left    = 0;
   int          quiet         = 0;
   logic [7:0]  threshold_now = ThresholdReset;

   always #5 clock = ~clock;

   line_sensor_pid_steer_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   steer_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!rsp_stall && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet + 1 >= WatchdogLimit) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic [4:0] pattern_of(input int k);
      case (k)
         0:       return 5'b00001;
         1:       return 5'b00011;
         2:       return 5'b00010;
         3:       return 5'b00110;
         4:       return 5'b00100;
         5:       return 5'b01100;
         6:       return 5'b01000;
         7:       return 5'b11000;
         default: return 5'b10000;
      endcase
   endfunction

   function automatic logic [7:0] level_for(input bit lit);
      int thr;
      int pick;
      thr  = threshold_now;
      pick = $urandom_range(0, 3);
      if (lit && thr < 255) begin
         if (pick == 0) return 8'(thr + 1);
         if (pick == 1) return 8'd255;
         return 8'($urandom_range(thr + 1, 255));
      end
      if (lit) return 8'd255;
      if (pick == 0) return 8'(thr);
      if (pick == 1) return 8'd0;
      return 8'($urandom_range(0, thr));
   endfunction

   function automatic req_type shape(input logic [4:0] pat, input logic [15:0] ms);
      req_type r;
      r.level_far_left  = level_for(pat[4]);
      r.level_left      = level_for(pat[3]);
      r.level_mid       = level_for(pat[2]);
      r.level_right     = level_for(pat[1]);
      r.level_far_right = level_for(pat[0]);
      r.elapsed_ms      = ms;
      return r;
   endfunction

   function automatic logic [15:0] pick_ms();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic logic [15:0] random_gain();
      if ($urandom_range(0, 1) == 1) return 16'($urandom);
      return 16'($urandom_range(0, 1023) - 512);
   endfunction

   task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type c);
      put_reg(RegPropGain, c.prop_gain);
      put_reg(RegIntegGain, c.integ_gain);
      put_reg(RegDerivGain, c.deriv_gain);
      put_reg(RegBaseSpeed, c.base_speed);
      put_reg(RegDarkThreshold, {8'($urandom), c.dark_threshold});
      put_reg(RegSpare, 16'($urandom));
      csr_write_en <= 1'b0;
      threshold_now = c.dark_threshold;
   endtask

   task automatic send_item(input req_type sample);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type cfg;
      req_type sample;
      int      track;
      int      roll;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // Reset settings: every line position, lost patterns and field extremes.
      for (int k = 0; k < 9; k++) send_item(shape(pattern_of(k), 16'd1));
      send_item('{8'd60, 8'd60, 8'd60, 8'd60, 8'd60, 16'd0});
      send_item('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF});
      send_item('{8'd60, 8'd60, 8'd61, 8'd60, 8'd60, 16'd2});
      send_item('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF});
      send_item(shape(5'b10001, 16'd3));
      send_item(shape(5'b01010, 16'd0));
      drain();

      cfg = '{16'sd100, 16'sd3, -16'sd500, 16'sd1000, 8'd128};
      configure(cfg);
      for (int k = 8; k >= 0; k--) begin
         send_item(shape(pattern_of(k), (k % 2 == 1) ? 16'd0 : 16'hFFFF));
      end
      drain();

      track = 4;
      for (int p = 0; p < RandomPhases; p++) begin
         if (p == 0) begin
            cfg = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd0};
         end else if (p == 1) begin
            cfg = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 8'd255};
         end else begin
            cfg.prop_gain      = random_gain();
            cfg.integ_gain     = random_gain();
            cfg.deriv_gain     = random_gain();
            cfg.base_speed     = random_gain();
            cfg.dark_threshold = 8'($urandom_range(0, 255));
         end
         configure(cfg);
         idle_on = (p != RandomPhases - 1) && (p % 3 != 2);
         for (int n = 0; n < PhaseItems; n++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               sample.level_far_left  = 8'($urandom);
               sample.level_left      = 8'($urandom);
               sample.level_mid       = 8'($urandom);
               sample.level_right     = 8'($urandom);
               sample.level_far_right = 8'($urandom);
               sample.elapsed_ms      = 16'($urandom);
            end else if (roll == 1) begin
               sample = shape(5'($urandom), pick_ms());
            end else begin
               case ($urandom_range(0, 5))
                  0:       track = (track > 0) ? track - 1 : 0;
                  1:       track = (track < 8) ? track + 1 : 8;
                  2:       track = $urandom_range(0, 8);
                  default: ;
               endcase
               sample = shape(pattern_of(track), pick_ms());
            end
            send_item(sample);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
